// ----- rtl/brb_pkg.sv -----
// Shared types and constants for the byte ring buffer with peek.
package brb_pkg;

  localparam int DATA_W    = 8;
  localparam int ACT_W     = 3;
  localparam int OFFSET_W  = 12;
  localparam int COUNT_W   = 7;
  localparam int LEVEL_W   = 13;
  localparam int CAP_W     = 13;
  localparam int CAP_RESET = 4096;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUT   = 3'd0,
    ACT_GET   = 3'd1,
    ACT_PEEK  = 3'd2,
    ACT_RESET = 3'd3,
    ACT_WIPE  = 3'd4
  } action_t;

  typedef struct packed {
    logic we;
    logic re;
  } ram_ctl_t;

endpackage

// ----- rtl/brb_ram.sv -----
// Single-port byte store with a registered read.
module brb_ram #(
  parameter int ADDR_W = 12
) (
  input  logic                       clk,
  input  brb_pkg::ram_ctl_t          ctl,
  input  logic [ADDR_W-1:0]          addr,
  input  logic [brb_pkg::DATA_W-1:0] wdata,
  output logic [brb_pkg::DATA_W-1:0] rdata
);

  logic [brb_pkg::DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[addr] <= wdata;
    end else if (ctl.re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ----- rtl/byte_ring_buffer_with_peek_core.sv -----
// Byte ring buffer with peek: put, get, peek, reset and wipe of a circular byte store.
// Put, reset, null get or peek: one result in the cycle after accept; busy stays low, one item a cycle.
// Get or peek of n bytes: accept enters the burst state, whose reads return the bytes through
// the result registers, one a cycle from the store's single read port; busy is high in the burst.
// Wipe: result in the cycle after accept, then busy while the clearing pass zeroes entries 0 to
// DEPTH-1 one entry a cycle. Synchronous active-low reset empties the ring; the store is kept.
module byte_ring_buffer_with_peek_core #(
  parameter int DEPTH     = 4096,
  parameter int MAX_BURST = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [brb_pkg::ACT_W-1:0]     in_action,
  input  logic [brb_pkg::DATA_W-1:0]    in_data_in,
  input  logic [brb_pkg::OFFSET_W-1:0]  in_offset,
  input  logic [brb_pkg::COUNT_W-1:0]   in_count,
  input  logic                          cfg_we,
  input  logic [brb_pkg::CAP_W-1:0]     cfg_wdata,
  output logic                          out_strobe,
  output logic [brb_pkg::DATA_W-1:0]    out_data_out,
  output logic                          out_byte_valid,
  output logic                          out_accepted,
  output logic [brb_pkg::LEVEL_W-1:0]   out_level,
  output logic                          out_last
);

  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW      = $clog2(DEPTH + 1);
  localparam int WW      = (LW > brb_pkg::OFFSET_W) ? LW + 1 : brb_pkg::OFFSET_W + 1;
  localparam int SW      = WW + 1;
  localparam int CW      = brb_pkg::COUNT_W;
  localparam int LVW     = brb_pkg::LEVEL_W;
  localparam int CAP_RST = (DEPTH < brb_pkg::CAP_RESET) ? DEPTH : brb_pkg::CAP_RESET;

  typedef enum logic [1:0] {ST_IDLE, ST_BURST, ST_WIPE} state_t;

  state_t              state_r, state_nxt;
  logic [AW-1:0]       rd_idx_r, rd_idx_nxt;
  logic [AW-1:0]       wr_idx_r, wr_idx_nxt;
  logic [LW-1:0]       lvl_r, lvl_nxt;
  logic [LW-1:0]       cap_r, cap_nxt;
  logic [AW-1:0]       ptr_r, ptr_nxt;
  logic [CW-1:0]       rem_r, rem_nxt;
  logic                is_get_r, is_get_nxt;
  logic [AW-1:0]       clr_ptr_r, clr_ptr_nxt;
  logic                out_strobe_r, out_strobe_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_acc_r, out_acc_nxt;
  logic [LW-1:0]       out_level_r, out_level_nxt;
  logic                out_last_r, out_last_nxt;

  logic                accept;
  logic [CW-1:0]       cnt_sat;
  logic [CW-1:0]       n_get;
  logic [CW-1:0]       n_peek;
  logic [WW-1:0]       avail;
  logic [SW-1:0]       pos_sum;
  logic [AW-1:0]       peek_pos;
  logic [LW-1:0]       cap_cfg;

  brb_pkg::ram_ctl_t           ram_ctl;
  logic [AW-1:0]               ram_addr;
  logic [brb_pkg::DATA_W-1:0]  ram_wdata;
  logic [brb_pkg::DATA_W-1:0]  ram_rdata;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] idx,
                                             input logic [LW-1:0] cap);
    logic [LW-1:0] nx;
    nx = LW'(idx) + LW'(1);
    return (nx == cap) ? '0 : AW'(nx);
  endfunction

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  // Burst length and peek start position, worked out in the accept cycle, and the clamped capacity write value.
  always_comb begin
    cnt_sat  = (in_count > CW'(MAX_BURST)) ? CW'(MAX_BURST) : in_count;
    n_get    = (WW'(cnt_sat) < WW'(lvl_r)) ? cnt_sat : CW'(lvl_r);
    avail    = WW'(lvl_r) - WW'(in_offset);
    n_peek   = (WW'(cnt_sat) < avail) ? cnt_sat : CW'(avail);
    pos_sum  = SW'(rd_idx_r) + SW'(in_offset);
    peek_pos = (pos_sum >= SW'(cap_r)) ? AW'(pos_sum - SW'(cap_r)) : AW'(pos_sum);
    if (cfg_wdata == '0) begin
      cap_cfg = LW'(1);
    end else if (32'(cfg_wdata) > 32'(DEPTH)) begin
      cap_cfg = LW'(DEPTH);
    end else begin
      cap_cfg = LW'(cfg_wdata);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    rd_idx_nxt     = rd_idx_r;
    wr_idx_nxt     = wr_idx_r;
    lvl_nxt        = lvl_r;
    cap_nxt        = cap_r;
    ptr_nxt        = ptr_r;
    rem_nxt        = rem_r;
    is_get_nxt     = is_get_r;
    clr_ptr_nxt    = clr_ptr_r;
    out_strobe_nxt = 1'b0;
    out_valid_nxt  = 1'b0;
    out_acc_nxt    = 1'b0;
    out_level_nxt  = out_level_r;
    out_last_nxt   = 1'b0;
    ram_ctl        = '0;
    ram_addr       = wr_idx_r;
    ram_wdata      = in_data_in;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_strobe_nxt = 1'b1;
          out_last_nxt   = 1'b1;
          out_level_nxt  = lvl_r;
          unique case (in_action)
            brb_pkg::ACT_PUT: begin
              if (lvl_r < cap_r) begin
                ram_ctl.we    = 1'b1;
                wr_idx_nxt    = wrap_inc(wr_idx_r, cap_r);
                lvl_nxt       = lvl_r + LW'(1);
                out_acc_nxt   = 1'b1;
                out_level_nxt = lvl_r + LW'(1);
              end
            end
            brb_pkg::ACT_GET: begin
              if (n_get != '0) begin
                out_strobe_nxt = 1'b0;
                out_last_nxt   = 1'b0;
                state_nxt      = ST_BURST;
                ptr_nxt        = rd_idx_r;
                rem_nxt        = n_get;
                is_get_nxt     = 1'b1;
              end
            end
            brb_pkg::ACT_PEEK: begin
              if ((WW'(in_offset) < WW'(lvl_r)) && (cnt_sat != '0)) begin
                out_strobe_nxt = 1'b0;
                out_last_nxt   = 1'b0;
                state_nxt      = ST_BURST;
                ptr_nxt        = peek_pos;
                rem_nxt        = n_peek;
                is_get_nxt     = 1'b0;
              end
            end
            brb_pkg::ACT_RESET: begin
              rd_idx_nxt    = '0;
              wr_idx_nxt    = '0;
              lvl_nxt       = '0;
              out_level_nxt = '0;
            end
            brb_pkg::ACT_WIPE: begin
              rd_idx_nxt    = '0;
              wr_idx_nxt    = '0;
              lvl_nxt       = '0;
              out_level_nxt = '0;
              clr_ptr_nxt   = '0;
              state_nxt     = ST_WIPE;
            end
            default: begin
            end
          endcase
        end
      end
      ST_BURST: begin
        // One read a cycle; the byte appears with the result registers on the next cycle.
        ram_ctl.re     = 1'b1;
        ram_addr       = ptr_r;
        ptr_nxt        = wrap_inc(ptr_r, cap_r);
        rem_nxt        = rem_r - CW'(1);
        out_strobe_nxt = 1'b1;
        out_valid_nxt  = 1'b1;
        out_last_nxt   = (rem_r == CW'(1));
        out_level_nxt  = lvl_r;
        if (is_get_r) begin
          rd_idx_nxt    = wrap_inc(ptr_r, cap_r);
          lvl_nxt       = lvl_r - LW'(1);
          out_level_nxt = lvl_r - LW'(1);
        end
        if (rem_r == CW'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_WIPE: begin
        ram_ctl.we  = 1'b1;
        ram_addr    = clr_ptr_r;
        ram_wdata   = '0;
        clr_ptr_nxt = clr_ptr_r + AW'(1);
        if (clr_ptr_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // A capacity write also empties the ring.
    if (cfg_we) begin
      cap_nxt    = cap_cfg;
      rd_idx_nxt = '0;
      wr_idx_nxt = '0;
      lvl_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rd_idx_r     <= '0;
      wr_idx_r     <= '0;
      lvl_r        <= '0;
      cap_r        <= LW'(CAP_RST);
      rem_r        <= '0;
      is_get_r     <= 1'b0;
      clr_ptr_r    <= '0;
      out_strobe_r <= 1'b0;
      out_valid_r  <= 1'b0;
      out_acc_r    <= 1'b0;
      out_last_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rd_idx_r     <= rd_idx_nxt;
      wr_idx_r     <= wr_idx_nxt;
      lvl_r        <= lvl_nxt;
      cap_r        <= cap_nxt;
      rem_r        <= rem_nxt;
      is_get_r     <= is_get_nxt;
      clr_ptr_r    <= clr_ptr_nxt;
      out_strobe_r <= out_strobe_nxt;
      out_valid_r  <= out_valid_nxt;
      out_acc_r    <= out_acc_nxt;
      out_last_r   <= out_last_nxt;
    end
    ptr_r       <= ptr_nxt;
    out_level_r <= out_level_nxt;
  end

  brb_ram #(
    .ADDR_W (AW)
  ) u_store (
    .clk   (clk),
    .ctl   (ram_ctl),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign out_strobe     = out_strobe_r;
  assign out_byte_valid = out_valid_r;
  assign out_accepted   = out_acc_r;
  assign out_last       = out_last_r;
  assign out_level      = LVW'(out_level_r);
  assign out_data_out   = out_valid_r ? ram_rdata : '0;

  a_level_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    lvl_r <= cap_r)
    else $error("fill level exceeds capacity");

  a_burst_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BURST) |-> (rem_r != '0))
    else $error("burst running with no bytes left");

  a_put_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !cfg_we && (in_action == brb_pkg::ACT_PUT) && (lvl_r < cap_r))
      |=> (lvl_r == $past(lvl_r) + LW'(1)) && out_accepted)
    else $error("accepted put did not raise the fill level");

  a_byte_only_from_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_strobe_r && !out_acc_r && ($past(state_r) == ST_BURST))
    else $error("byte result outside a burst");

  a_get_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BURST && is_get_r && !cfg_we) |=> (lvl_r == $past(lvl_r) - LW'(1)))
    else $error("get byte did not lower the fill level");

endmodule
